// File: hw/rtl/ermr_pkg.sv
// Shared types, constants and helpers of the event rule match engine.
`timescale 1ns / 1ps
package ermr_pkg;

    localparam int RULE_COUNT = 16;
    localparam int IDX_W      = $clog2(RULE_COUNT);
    localparam int NAME_BYTES = 32;
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int LEN_W      = 6;
    localparam int ADDR_W     = 48;
    localparam int SCORE_W    = 16;
    localparam int FIRE_W     = 32;

    // request types
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_EVENT  = 2'd2;

    // event kinds
    localparam logic [2:0] KIND_AP        = 3'd0;
    localparam logic [2:0] KIND_JOIN      = 3'd1;
    localparam logic [2:0] KIND_ANOMALY   = 3'd2;
    localparam logic [2:0] KIND_BLE       = 3'd3;
    localparam logic [2:0] KIND_HANDSHAKE = 3'd4;
    localparam logic [2:0] KIND_ROGUE     = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [1:0] ST_NO_FIRE  = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         rule_slot;
        logic [2:0]         event_kind;
        logic [2:0]         action_code;
        logic [1:0]         action_arg;
        logic [ADDR_W-1:0]  addr;
        logic [SCORE_W-1:0] score;
        logic [LEN_W-1:0]   text_len;
        logic [63:0]        text_w0;
        logic [63:0]        text_w1;
        logic [63:0]        text_w2;
        logic [63:0]        text_w3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              fired;
        logic [3:0]        rule_index;
        logic [2:0]        out_action;
        logic [1:0]        out_arg;
        logic [ADDR_W-1:0] out_addr;
        logic [FIRE_W-1:0] fire_total;
        logic              last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic add_do;
        logic rem_do;
        logic scan_step;
        logic flush;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] in_req;
        logic       out_free;
        logic       hit;
        logic       hold_vld;
        logic       idx_last;
    } t_sts;

    // byte mask of the first len bytes of a name
    function automatic logic [NAME_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [NAME_W-1:0] m;
        m = '0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            m[8*b +: 8] = (int'(len) > b) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/ermr_ctrl.sv
// Sequencing state machine of the event rule match engine.
`timescale 1ns / 1ps
module ermr_ctrl import ermr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_REM   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_step_ok;

    assign o_in_stall = (r_state != S_IDLE);
    // a second hit needs the output register to push the held one out
    assign w_step_ok  = !(i_sts.hit && i_sts.hold_vld && !i_sts.out_free);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_sts.in_req)
                        REQ_ADD:    n_state = S_ADD;
                        REQ_REMOVE: n_state = S_REM;
                        REQ_EVENT:  n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_REM: begin
                if (i_sts.out_free) begin
                    o_cmd.rem_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = w_step_ok;
                if (w_step_ok && i_sts.idx_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/ermr_dp.sv
// Rule table, scan datapath and output register of the event rule match engine.
`timescale 1ns / 1ps
module ermr_dp import ermr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    // rule table
    logic [RULE_COUNT-1:0] r_en;
    logic [2:0]            r_kind [RULE_COUNT];
    logic [2:0]            r_act  [RULE_COUNT];
    logic [1:0]            r_arg  [RULE_COUNT];
    logic [ADDR_W-1:0]     r_addr [RULE_COUNT];
    logic [SCORE_W-1:0]    r_thr  [RULE_COUNT];
    logic [LEN_W-1:0]      r_len  [RULE_COUNT];
    logic [NAME_W-1:0]     r_pfx  [RULE_COUNT];

    // captured request
    t_in_item          r_q;
    logic [NAME_W-1:0] r_name;

    logic [IDX_W-1:0]  r_idx;
    logic [FIRE_W-1:0] r_fire;
    t_out_item         r_hold;
    logic              r_hold_vld;
    t_out_item         r_out;
    logic              r_out_vld;

    logic              w_out_free;
    logic              w_hit;
    logic              w_addr_ok;
    logic              w_name_ok;
    logic              w_free_any;
    logic [IDX_W-1:0]  w_free_idx;
    logic [LEN_W-1:0]  w_len_sat;
    logic              w_slot_ok;
    logic              w_out_load;
    t_out_item         w_hit_item;
    t_out_item         w_res;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_out_load = i_cmd.add_do || i_cmd.rem_do || i_cmd.flush ||
                        (i_cmd.scan_step && w_hit && r_hold_vld);

    // lowest free slot
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = RULE_COUNT - 1; i >= 0; i--) begin
            if (!r_en[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_len_sat = (int'(r_q.text_len) > NAME_BYTES) ? LEN_W'(NAME_BYTES) : r_q.text_len;
    assign w_slot_ok = int'(r_q.rule_slot) < RULE_COUNT;

    // match of the rule under the scan index
    assign w_addr_ok = (r_addr[r_idx] == '0) || (r_addr[r_idx] == r_q.addr);
    assign w_name_ok = ((r_name & prefix_mask(r_len[r_idx])) == r_pfx[r_idx]);

    always_comb begin
        w_hit = 1'b0;
        if (r_en[r_idx] && (r_kind[r_idx] == r_q.event_kind)) begin
            case (r_q.event_kind)
                KIND_AP:        w_hit = w_addr_ok && w_name_ok;
                KIND_JOIN:      w_hit = w_addr_ok;
                KIND_BLE:       w_hit = w_addr_ok;
                KIND_ANOMALY:   w_hit = (r_q.score >= r_thr[r_idx]);
                KIND_HANDSHAKE: w_hit = 1'b1;
                KIND_ROGUE:     w_hit = w_name_ok;
                default:        w_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        w_hit_item            = '0;
        w_hit_item.status     = ST_OK;
        w_hit_item.fired      = 1'b1;
        w_hit_item.rule_index = 4'(r_idx);
        w_hit_item.out_action = r_act[r_idx];
        w_hit_item.out_arg    = r_arg[r_idx];
        w_hit_item.out_addr   = r_addr[r_idx];
        w_hit_item.fire_total = r_fire + FIRE_W'(1);
        w_hit_item.last       = 1'b0;
    end

    // result loaded into the output register this cycle
    always_comb begin
        w_res            = '0;
        w_res.fire_total = r_fire;
        w_res.last       = 1'b1;
        if (i_cmd.add_do) begin
            w_res.status     = w_free_any ? ST_OK : ST_FULL;
            w_res.rule_index = w_free_any ? 4'(w_free_idx) : 4'd0;
        end else if (i_cmd.rem_do) begin
            w_res.status     = w_slot_ok ? ST_OK : ST_BAD_SLOT;
            w_res.rule_index = r_q.rule_slot;
        end else if (i_cmd.flush) begin
            if (r_hold_vld) begin
                w_res      = r_hold;
                w_res.last = 1'b1;
            end else begin
                w_res.status = ST_NO_FIRE;
            end
        end else begin
            w_res = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en       <= '0;
            r_fire     <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (w_out_free) begin
                r_out_vld <= 1'b0;
            end
            // hold register empties on a new transaction or on the final flush
            if (i_cmd.capture || i_cmd.flush) begin
                r_hold_vld <= 1'b0;
            end
            if (i_cmd.add_do && w_free_any) begin
                r_en[w_free_idx] <= 1'b1;
            end
            if (i_cmd.rem_do && w_slot_ok) begin
                r_en[r_q.rule_slot[IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.scan_step && w_hit) begin
                r_fire     <= r_fire + FIRE_W'(1);
                r_hold_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q    <= i_in;
            r_name <= {i_in.text_w3, i_in.text_w2, i_in.text_w1, i_in.text_w0};
            r_idx  <= '0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.add_do && w_free_any) begin
            r_kind[w_free_idx] <= r_q.event_kind;
            r_act[w_free_idx]  <= r_q.action_code;
            r_arg[w_free_idx]  <= r_q.action_arg;
            r_addr[w_free_idx] <= r_q.addr;
            r_thr[w_free_idx]  <= r_q.score;
            r_len[w_free_idx]  <= w_len_sat;
            r_pfx[w_free_idx]  <= r_name & prefix_mask(w_len_sat);
        end
        if (i_cmd.scan_step && w_hit) begin
            r_hold <= w_hit_item;
        end
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_sts.in_req   = i_in.req_type;
    assign o_sts.out_free = w_out_free;
    assign o_sts.hit      = w_hit;
    assign o_sts.hold_vld = r_hold_vld;
    assign o_sts.idx_last = (r_idx == IDX_W'(RULE_COUNT - 1));

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: hw/rtl/event_rule_match_engine_core.sv
// Top level of the event rule match engine: controller plus datapath.
// Add and remove: one transaction in, one result out once the output register is free.
// Event: accept, scan one rule slot per cycle unless a second hit awaits the output, flush.
// The scan over the rule table sets the rate; one request is handled at a time.
// A matched result waits in a hold register so the final one can carry last.
// Reset (i_rst_n low, synchronous) clears the enabled flags and the fire counter.
`timescale 1ns / 1ps
module event_rule_match_engine_core import ermr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    // command and status between the two halves
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: idle / add / remove / scan / flush
    ermr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // rule table, match logic, fire counter and output register
    ermr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // a fired result always reports ok status
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.fired |-> o_out.status == ST_OK)
        else $error("fired result with non-ok status");

    // results that report no match end their request
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.fired |-> o_out.last)
        else $error("unfired result not marked last");

    // nothing is left in the hold register once ready for a new transaction
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_sts.hold_vld)
        else $error("held match left behind at idle");

endmodule

// File: test/event_rule_match_engine_core_tb.sv
// Testbench of the event rule match engine: random and directed requests against a rule table model.
`timescale 1ns / 1ps
module event_rule_match_engine_core_tb;
    import ermr_pkg::*;

    // rule table model plus queue of expected results
    class rule_table_sb;
        bit          en     [RULE_COUNT];
        logic [2:0]  kind   [RULE_COUNT];
        logic [2:0]  act    [RULE_COUNT];
        logic [1:0]  arg    [RULE_COUNT];
        logic [47:0] addr   [RULE_COUNT];
        logic [15:0] thr    [RULE_COUNT];
        logic [5:0]  plen   [RULE_COUNT];
        logic [NAME_W-1:0] pfx [RULE_COUNT];
        logic [31:0] fires;
        t_out_item   pending[$];
        int          errors;

        function new();
            for (int i = 0; i < RULE_COUNT; i++) clear_slot(i);
            fires = '0;
            errors = 0;
        endfunction

        function void clear_slot(int i);
            en[i] = 0; kind[i] = '0; act[i] = '0; arg[i] = '0;
            addr[i] = '0; thr[i] = '0; plen[i] = '0; pfx[i] = '0;
        endfunction

        function logic [NAME_W-1:0] byte_mask(int len);
            logic [NAME_W-1:0] m;
            m = '0;
            for (int b = 0; b < NAME_BYTES; b++)
                if (b < len) m[8*b +: 8] = 8'hFF;
            return m;
        endfunction

        function t_out_item mk(logic [1:0] st, logic f, logic [3:0] idx, logic l);
            t_out_item r;
            r = '0;
            r.status = st; r.fired = f; r.rule_index = idx;
            r.fire_total = fires; r.last = l;
            return r;
        endfunction

        // note an accepted request and queue its results
        function void note_request(t_in_item t);
            logic [NAME_W-1:0] name;
            int len, n, slot;
            bit hit, am, nm;
            t_out_item r;
            name = {t.text_w3, t.text_w2, t.text_w1, t.text_w0};
            if (t.req_type == REQ_ADD) begin
                len = (int'(t.text_len) > NAME_BYTES) ? NAME_BYTES : int'(t.text_len);
                slot = -1;
                for (int i = 0; i < RULE_COUNT; i++)
                    if (!en[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    pending.push_back(mk(ST_FULL, 1'b0, 4'd0, 1'b1));
                end else begin
                    en[slot] = 1; kind[slot] = t.event_kind; act[slot] = t.action_code;
                    arg[slot] = t.action_arg; addr[slot] = t.addr; thr[slot] = t.score;
                    plen[slot] = 6'(len); pfx[slot] = name & byte_mask(len);
                    pending.push_back(mk(ST_OK, 1'b0, 4'(slot), 1'b1));
                end
            end else if (t.req_type == REQ_REMOVE) begin
                clear_slot(int'(t.rule_slot));
                pending.push_back(mk(ST_OK, 1'b0, t.rule_slot, 1'b1));
            end else if (t.req_type == REQ_EVENT) begin
                n = 0;
                for (int i = 0; i < RULE_COUNT; i++) begin
                    if (!en[i] || kind[i] != t.event_kind) continue;
                    am = (addr[i] == 0) || (addr[i] == t.addr);
                    nm = ((name & byte_mask(int'(plen[i]))) == pfx[i]);
                    case (t.event_kind)
                        KIND_AP:             hit = am && nm;
                        KIND_JOIN, KIND_BLE: hit = am;
                        KIND_ANOMALY:        hit = t.score >= thr[i];
                        KIND_HANDSHAKE:      hit = 1;
                        KIND_ROGUE:          hit = nm;
                        default:             hit = 0;
                    endcase
                    if (!hit) continue;
                    fires = fires + 32'd1;
                    r = mk(ST_OK, 1'b1, 4'(i), 1'b0);
                    r.out_action = act[i]; r.out_arg = arg[i]; r.out_addr = addr[i];
                    pending.push_back(r);
                    n++;
                end
                if (n == 0) pending.push_back(mk(ST_NO_FIRE, 1'b0, 4'd0, 1'b1));
                else pending[$].last = 1;
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(t_out_item g);
            t_out_item w;
            if (pending.size() == 0) begin
                report("unexpected result", 64'(g.rule_index), 64'd0);
                return;
            end
            w = pending.pop_front();
            if (g.status     !== w.status)
                report("status", 64'(g.status), 64'(w.status));
            if (g.fired      !== w.fired)
                report("fired", 64'(g.fired), 64'(w.fired));
            if (g.rule_index !== w.rule_index)
                report("rule_index", 64'(g.rule_index), 64'(w.rule_index));
            if (g.out_action !== w.out_action)
                report("out_action", 64'(g.out_action), 64'(w.out_action));
            if (g.out_arg    !== w.out_arg)
                report("out_arg", 64'(g.out_arg), 64'(w.out_arg));
            if (g.out_addr   !== w.out_addr)
                report("out_addr", 64'(g.out_addr), 64'(w.out_addr));
            if (g.fire_total !== w.fire_total)
                report("fire_total", 64'(g.fire_total), 64'(w.fire_total));
            if (g.last       !== w.last)
                report("last", 64'(g.last), 64'(w.last));
        endtask
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_item o_out;

    rule_table_sb sb = new();
    int  cycles = 0;
    bit  long_hold = 0;   // request for a long output hold-off
    bit  stim_done = 0;

    event_rule_match_engine_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAIL event_rule_match_engine_core");
            $finish;
        end
    end

    // result side: check accepted transactions, stall on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
    end

    initial begin
        int run, mode;
        mode = 0;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1;
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end
            run = $urandom_range(1, 20);
            mode = $urandom_range(0, 3);
            repeat (run) begin
                case (mode)
                    0: i_out_stall <= 0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // input side: offer one transaction and hold it until accepted
    task send(t_in_item t);
        i_in <= t;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(t);
    endtask

    task gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function t_in_item rand_item(logic [1:0] req);
        t_in_item t;
        logic [351:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        t = raw[$bits(t_in_item)-1:0];
        t.req_type = req;
        t.event_kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
        t.text_len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                 : 6'($urandom_range(0, 12));
        if ($urandom_range(0, 2) == 0) t.addr = 48'h0000_0000_00A5 + 48'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) t.addr = '0;
        if ($urandom_range(0, 1) == 0) begin
            // small name alphabet so prefixes often match
            t.text_w0 = {8{8'h41}} + 64'($urandom_range(0, 3));
            t.text_w1 = '0; t.text_w2 = '0; t.text_w3 = '0;
        end
        return t;
    endfunction

    task wait_drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        t_in_item t;
        int p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, each kind, extremes, full table, bad-free cases
        t = '0; t.req_type = REQ_EVENT; t.event_kind = KIND_HANDSHAKE; send(t);
        t = '1; t.req_type = 2'd3; i_in <= t; i_in_valid <= 1;   // ignored type
        @(posedge i_clk); while (o_in_stall) @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            t = '1; t.req_type = REQ_ADD; t.event_kind = 3'(k); t.action_code = 3'(k);
            t.addr = (k[0]) ? '0 : '1; t.score = (k == 2) ? 16'h8000 : '1;
            t.text_len = (k == 5) ? 6'd63 : ((k == 0) ? 6'd0 : 6'd3);
            send(t);
        end
        for (int k = 0; k < 8; k++) begin
            t = '1; t.req_type = REQ_EVENT; t.event_kind = 3'(k); t.score = 16'h8000;
            send(t);
        end
        for (int k = 0; k < 9; k++) begin
            t = '0; t.req_type = REQ_ADD; t.event_kind = KIND_HANDSHAKE; t.action_arg = 3;
            send(t);
        end
        t = '0; t.req_type = REQ_EVENT; t.event_kind = KIND_HANDSHAKE; send(t);
        t = '0; t.req_type = REQ_REMOVE; t.rule_slot = 4'd15; send(t);
        t = '1; t.req_type = REQ_REMOVE; send(t);
        wait_drain();

        // random: events half the time, adds and removes otherwise
        for (int n = 0; n < 80; n++) begin
            if (n == 40) long_hold = 1;
            if (n == 70) wait_drain();
            p = $urandom_range(0, 9);
            if (p < 3)      t = rand_item(REQ_ADD);
            else if (p < 5) t = rand_item(REQ_REMOVE);
            else            t = rand_item(REQ_EVENT);
            send(t);
            gap();
        end
        wait_drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS event_rule_match_engine_core");
        else
            $display("FAIL event_rule_match_engine_core");
        $finish;
    end
endmodule
